// ----- src/mtp_pkg.sv -----
`timescale 1ns / 1ps
package mtp_pkg;

	localparam int POS_FRAC_BITS   = 16;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int SUM_WIDTH       = 48;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 3'd5;

	// Pi in Q32, rounded into the angle format.
	localparam longint unsigned PI_Q32 = 64'd13493037705;
	localparam longint ANG_PI_L = longint'((PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
		>> (32 - ANGLE_FRAC_BITS));
	localparam logic signed [17:0] ANG_PI     = 18'(ANG_PI_L);
	localparam logic signed [17:0] ANG_TWO_PI = 18'(2 * ANG_PI_L);

	localparam int SHL = (POS_FRAC_BITS >= ANGLE_FRAC_BITS) ? POS_FRAC_BITS - ANGLE_FRAC_BITS : 0;
	localparam int SHR = (ANGLE_FRAC_BITS > POS_FRAC_BITS) ? ANGLE_FRAC_BITS - POS_FRAC_BITS : 0;

	localparam int OPW   = (SUM_WIDTH > 34) ? SUM_WIDTH : 34;
	localparam int PRODW = OPW + 17;
	localparam int ACC_W = PRODW + 2;
	localparam int SCL_W = 65;
	localparam int ROOT_STEPS = 32;
	localparam int CNT_W = $clog2(ROOT_STEPS);

	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     latch;
		logic     sq_x;
		logic     sq_y;
		logic     root_load;
		logic     root_step;
		logic     dist_err;
		logic     ang_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     mul_ang;
		logic     acc_load;
		logic     acc_add;
		logic     lin_fin;
		logic     ang_fin;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic root_last;
		logic out_free;
	} status_t;

	function automatic logic signed [SUM_WIDTH-1:0] sat_add(
		input logic signed [SUM_WIDTH-1:0] s,
		input logic signed [33:0] e
	);
		logic signed [SUM_WIDTH+3:0] t;
		logic signed [SUM_WIDTH+3:0] hi;
		logic signed [SUM_WIDTH+3:0] lo;
		hi = $signed({5'b00000, {(SUM_WIDTH-1){1'b1}}});
		lo = -hi - 1;
		t = (SUM_WIDTH+4)'(s) + (SUM_WIDTH+4)'(e);
		if (t > hi)
			return hi[SUM_WIDTH-1:0];
		if (t < lo)
			return lo[SUM_WIDTH-1:0];
		return t[SUM_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > $signed(96'h7FFF_FFFF))
			return 32'h7FFF_FFFF;
		if (v < -$signed(96'h8000_0000))
			return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage

// ----- src/mtp_if.sv -----
`timescale 1ns / 1ps
interface mtp_in_if;
	logic               valid;
	logic               ready;
	logic               odom_valid;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [14:0] yaw;
	logic               obstacle_valid;
	logic signed [31:0] obstacle_distance;
	logic               cmd_valid;
	logic signed [31:0] cmd_translation;
	logic signed [14:0] cmd_rotation;
	modport source(output valid, odom_valid, pos_x, pos_y, yaw, obstacle_valid,
		obstacle_distance, cmd_valid, cmd_translation, cmd_rotation, input ready);
	modport sink(input valid, odom_valid, pos_x, pos_y, yaw, obstacle_valid,
		obstacle_distance, cmd_valid, cmd_translation, cmd_rotation, output ready);
endinterface

interface mtp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] linear_speed;
	logic signed [31:0] angular_speed;
	modport source(output valid, linear_speed, angular_speed, input ready);
	modport sink(input valid, linear_speed, angular_speed, output ready);
endinterface

interface mtp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mtp_pkg::CFG_IDX_W-1:0]   index;
	logic [mtp_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/mtp_datapath.sv -----
`timescale 1ns / 1ps
module mtp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mtp_pkg::cmd_t                  cmd,
	output mtp_pkg::status_t               status,
	input  logic                           cfg_valid,
	input  logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           odom_valid,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_y,
	input  logic signed [14:0]             yaw,
	input  logic                           obstacle_valid,
	input  logic signed [31:0]             obstacle_distance,
	input  logic                           cmd_valid,
	input  logic signed [31:0]             cmd_translation,
	input  logic signed [14:0]             cmd_rotation,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             linear_speed,
	output logic signed [31:0]             angular_speed
);

	logic [15:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] safety_q, dtol_q;
	logic [13:0] atol_q;

	logic signed [31:0] held_x_q, held_y_q, held_obs_q, start_x_q, start_y_q, dtarget_q;
	logic signed [14:0] held_yaw_q;
	logic signed [15:0] htarget_q;
	logic odom_seen_q, obs_seen_q, pending_q, translating_q, rotating_q;
	logic signed [mtp_pkg::SUM_WIDTH-1:0] dsum_q, tsum_q;
	logic signed [31:0] dlast_q, tlast_q;

	logic [63:0] sqa_q, sqb_q, rad_q;
	logic        ovf_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [mtp_pkg::CNT_W-1:0] cnt_q;

	logic signed [33:0] err_q, dd_q;
	logic lin_go_q, ang_go_q;
	logic signed [mtp_pkg::PRODW-1:0] prod_q;
	logic signed [mtp_pkg::ACC_W-1:0] acc_q;
	logic signed [31:0] lin_q, ang_q;
	logic out_valid_q;
	logic signed [31:0] out_lin_q, out_ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= 16'd128;
			gain_i_q <= 16'd0;
			gain_d_q <= 16'd0;
			safety_q <= 31'd32768;
			dtol_q   <= 31'd6554;
			atol_q   <= 14'd819;
		end else if (cfg_valid) begin
			case (cfg_index)
				mtp_pkg::REG_GAIN_P:    gain_p_q <= cfg_data[15:0];
				mtp_pkg::REG_GAIN_I:    gain_i_q <= cfg_data[15:0];
				mtp_pkg::REG_GAIN_D:    gain_d_q <= cfg_data[15:0];
				mtp_pkg::REG_SAFETY:    safety_q <= cfg_data[30:0];
				mtp_pkg::REG_DIST_TOL:  dtol_q   <= cfg_data[30:0];
				mtp_pkg::REG_ANGLE_TOL: atol_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Values after this word is latched, and the start-of-move decision.
	logic signed [31:0] x_n, y_n;
	logic signed [14:0] yaw_n;
	logic signed [15:0] ht_n;
	logic odom_n, obs_seen_n, pend_n, start;
	logic signed [17:0] hsum, hwrap;

	always_comb begin
		x_n        = odom_valid ? pos_x : held_x_q;
		y_n        = odom_valid ? pos_y : held_y_q;
		yaw_n      = odom_valid ? yaw : held_yaw_q;
		odom_n     = odom_seen_q | odom_valid;
		obs_seen_n = obs_seen_q | obstacle_valid;
		pend_n     = pending_q | cmd_valid;
		ht_n       = cmd_valid ? 16'(cmd_rotation) : htarget_q;
		start      = pend_n & odom_n & obs_seen_n;
		hsum       = 18'(ht_n) + 18'(yaw_n);
		if (hsum > mtp_pkg::ANG_PI)
			hwrap = hsum - mtp_pkg::ANG_TWO_PI;
		else if (hsum < -mtp_pkg::ANG_PI)
			hwrap = hsum + mtp_pkg::ANG_TWO_PI;
		else
			hwrap = hsum;
	end

	// Squares of the displacement share one multiplier.
	logic signed [32:0] dx, dy, dsel;
	logic [32:0] dmag;
	logic [63:0] sq;
	assign dx   = 33'(start_x_q) - 33'(held_x_q);
	assign dy   = 33'(start_y_q) - 33'(held_y_q);
	assign dsel = cmd.sq_y ? dy : dx;
	assign dmag = dsel[32] ? 33'(-dsel) : 33'(dsel);
	assign sq   = 64'(dmag[31:0]) * 64'(dmag[31:0]);

	logic [64:0] sqsum;
	logic [35:0] rem_t, trial;
	assign sqsum = 65'(sqa_q) + 65'(sqb_q);
	assign rem_t = {rem_q, rad_q[63:62]};
	assign trial = 36'({root_q, 2'b01});

	// Distance error, obstacle limit and stop test.
	logic signed [33:0] travel, e0, e1;
	logic [33:0] me0;
	logic signed [31:0] derr;
	logic [32:0] mobs, mderr;
	logic blocked, tr_new;

	always_comb begin
		travel  = ovf_q ? 34'sh0_FFFF_FFFF : $signed({2'b00, root_q});
		e0      = 34'(dtarget_q) - travel;
		me0     = e0[33] ? 34'(-e0) : 34'(e0);
		e1      = ($signed({1'b0, me0}) > 35'(held_obs_q)) ? 34'(held_obs_q) : e0;
		derr    = e1[31:0];
		mobs    = held_obs_q[31] ? 33'(-33'(held_obs_q)) : 33'(held_obs_q);
		mderr   = derr[31] ? 33'(-33'(derr)) : 33'(derr);
		blocked = mobs < 33'(safety_q);
		tr_new  = (mderr > 33'(dtol_q)) && !blocked;
	end

	// Heading error, wrapped once.
	logic signed [17:0] ae0, aerr;
	logic [17:0] maerr;
	logic rot_new;

	always_comb begin
		ae0 = 18'(htarget_q) - 18'(held_yaw_q);
		if (ae0 > mtp_pkg::ANG_PI)
			aerr = ae0 - mtp_pkg::ANG_TWO_PI;
		else if (ae0 < -mtp_pkg::ANG_PI)
			aerr = ae0 + mtp_pkg::ANG_TWO_PI;
		else
			aerr = ae0;
		maerr   = aerr[17] ? 18'(-aerr) : 18'(aerr);
		rot_new = maerr > 18'(atol_q);
	end

	// Shared gain multiplier.
	logic signed [mtp_pkg::OPW-1:0] mul_a;
	logic [15:0] mul_g;
	logic signed [mtp_pkg::PRODW-1:0] prod, term;

	always_comb begin
		case (cmd.mul_sel)
			mtp_pkg::MUL_P: begin
				mul_a = mtp_pkg::OPW'(err_q);
				mul_g = gain_p_q;
			end
			mtp_pkg::MUL_I: begin
				mul_a = cmd.mul_ang ? mtp_pkg::OPW'(tsum_q) : mtp_pkg::OPW'(dsum_q);
				mul_g = gain_i_q;
			end
			mtp_pkg::MUL_D: begin
				mul_a = mtp_pkg::OPW'(dd_q);
				mul_g = gain_d_q;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
	end

	assign prod = mul_a * $signed({1'b0, mul_g});
	assign term = prod_q >>> 8;

	// Turn rate: clamp, rescale to the position format, saturate.
	localparam logic signed [mtp_pkg::ACC_W-1:0] RAW_CAP = mtp_pkg::ACC_W'(64'd1 << 40);
	logic signed [mtp_pkg::ACC_W-1:0] rawc;
	logic signed [mtp_pkg::SCL_W-1:0] scaled;

	always_comb begin
		if (acc_q > RAW_CAP)
			rawc = RAW_CAP;
		else if (acc_q < -RAW_CAP)
			rawc = -RAW_CAP;
		else
			rawc = acc_q;
		scaled = (mtp_pkg::SCL_W'(rawc) <<< mtp_pkg::SHL) >>> mtp_pkg::SHR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q      <= '0;
			held_y_q      <= '0;
			held_yaw_q    <= '0;
			held_obs_q    <= '0;
			odom_seen_q   <= 1'b0;
			obs_seen_q    <= 1'b0;
			pending_q     <= 1'b0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			dtarget_q     <= '0;
			htarget_q     <= '0;
			translating_q <= 1'b0;
			rotating_q    <= 1'b0;
			dsum_q        <= '0;
			dlast_q       <= '0;
			tsum_q        <= '0;
			tlast_q       <= '0;
			cnt_q         <= '0;
			lin_go_q      <= 1'b0;
			ang_go_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.latch) begin
				held_x_q    <= x_n;
				held_y_q    <= y_n;
				held_yaw_q  <= yaw_n;
				if (obstacle_valid)
					held_obs_q <= obstacle_distance;
				odom_seen_q <= odom_n;
				obs_seen_q  <= obs_seen_n;
				if (cmd_valid)
					dtarget_q <= cmd_translation;
				if (start) begin
					pending_q     <= 1'b0;
					start_x_q     <= x_n;
					start_y_q     <= y_n;
					translating_q <= 1'b1;
					rotating_q    <= 1'b1;
					htarget_q     <= hwrap[15:0];
					tlast_q       <= 32'(hsum);
				end else begin
					pending_q <= pend_n;
					htarget_q <= ht_n;
				end
			end
			if (cmd.root_load)
				cnt_q <= '0;
			else if (cmd.root_step)
				cnt_q <= cnt_q + mtp_pkg::CNT_W'(1);
			if (cmd.dist_err) begin
				translating_q <= tr_new;
				lin_go_q      <= tr_new;
				if (tr_new) begin
					dsum_q  <= mtp_pkg::sat_add(dsum_q, 34'(derr));
					dlast_q <= derr;
				end else begin
					obs_seen_q <= 1'b0;
				end
			end
			if (cmd.ang_err) begin
				ang_go_q <= rotating_q && rot_new;
				if (rotating_q) begin
					rotating_q <= rot_new;
					if (rot_new) begin
						tsum_q  <= mtp_pkg::sat_add(tsum_q, 34'(aerr));
						tlast_q <= 32'(aerr);
					end
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_x)
			sqa_q <= sq;
		if (cmd.sq_y)
			sqb_q <= sq;
		if (cmd.root_load) begin
			rad_q  <= sqsum[63:0];
			ovf_q  <= sqsum[64];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q  <= 34'(rem_t - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_t[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.dist_err) begin
			err_q <= 34'(derr);
			dd_q  <= 34'(derr) - 34'(dlast_q);
		end
		if (cmd.ang_err) begin
			err_q <= 34'(aerr);
			dd_q  <= 34'(aerr) - 34'(tlast_q);
		end
		if (cmd.mul_en)
			prod_q <= prod;
		if (cmd.acc_load)
			acc_q <= mtp_pkg::ACC_W'(term);
		else if (cmd.acc_add)
			acc_q <= acc_q + mtp_pkg::ACC_W'(term);
		if (cmd.lin_fin)
			lin_q <= lin_go_q ? mtp_pkg::sat32(96'(acc_q)) : 32'sd0;
		if (cmd.ang_fin)
			ang_q <= ang_go_q ? mtp_pkg::sat32(96'(scaled)) : 32'sd0;
		if (cmd.out_load) begin
			out_lin_q <= (ang_q > 32'sd0) ? 32'sd0 : lin_q;
			out_ang_q <= (ang_q > 32'sd0) ? ang_q : 32'sd0;
		end
	end

	assign status.active    = odom_seen_q & translating_q & obs_seen_q;
	assign status.root_last = (cnt_q == {mtp_pkg::CNT_W{1'b1}});
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign linear_speed  = out_lin_q;
	assign angular_speed = out_ang_q;

`ifndef SYNTHESIS
	a_one_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_lin_q == 32'sd0 || out_ang_q == 32'sd0))
		else $error("both speeds nonzero in one word");
	a_turn_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !out_ang_q[31])
		else $error("negative turn rate reported");
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(translating_q) |-> !obs_seen_q)
		else $error("translation ended with obstacle still marked seen");
`endif

endmodule

// ----- src/mtp_ctrl.sv -----
`timescale 1ns / 1ps
module mtp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mtp_pkg::status_t status,
	output mtp_pkg::cmd_t    cmd
);

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_CHECK = 19'h00002,
		ST_SQX   = 19'h00004,
		ST_SQY   = 19'h00008,
		ST_SUM   = 19'h00010,
		ST_ROOT  = 19'h00020,
		ST_DERR  = 19'h00040,
		ST_DMP   = 19'h00080,
		ST_DMI   = 19'h00100,
		ST_DMD   = 19'h00200,
		ST_DMA   = 19'h00400,
		ST_DFIN  = 19'h00800,
		ST_AERR  = 19'h01000,
		ST_AMP   = 19'h02000,
		ST_AMI   = 19'h04000,
		ST_AMD   = 19'h08000,
		ST_AMA   = 19'h10000,
		ST_AFIN  = 19'h20000,
		ST_OUT   = 19'h40000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid)
					state_n = ST_CHECK;
			end
			ST_CHECK: state_n = status.active ? ST_SQX : ST_IDLE;
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_n  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_n  = ST_SUM;
			end
			ST_SUM: begin
				cmd.root_load = 1'b1;
				state_n       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last)
					state_n = ST_DERR;
			end
			ST_DERR: begin
				cmd.dist_err = 1'b1;
				state_n      = ST_DMP;
			end
			ST_DMP, ST_AMP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = mtp_pkg::MUL_P;
				cmd.mul_ang = (state_q == ST_AMP);
				state_n     = (state_q == ST_AMP) ? ST_AMI : ST_DMI;
			end
			ST_DMI, ST_AMI: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = mtp_pkg::MUL_I;
				cmd.mul_ang  = (state_q == ST_AMI);
				cmd.acc_load = 1'b1;
				state_n      = (state_q == ST_AMI) ? ST_AMD : ST_DMD;
			end
			ST_DMD, ST_AMD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = mtp_pkg::MUL_D;
				cmd.mul_ang = (state_q == ST_AMD);
				cmd.acc_add = 1'b1;
				state_n     = (state_q == ST_AMD) ? ST_AMA : ST_DMA;
			end
			ST_DMA, ST_AMA: begin
				cmd.acc_add = 1'b1;
				state_n     = (state_q == ST_AMA) ? ST_AFIN : ST_DFIN;
			end
			ST_DFIN: begin
				cmd.lin_fin = 1'b1;
				state_n     = ST_AERR;
			end
			ST_AERR: begin
				cmd.ang_err = 1'b1;
				state_n     = ST_AMP;
			end
			ST_AFIN: begin
				cmd.ang_fin = 1'b1;
				state_n     = ST_OUT;
			end
			ST_OUT: begin
				// Wait until the output register has room for the word.
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ----- src/move_turn_pid_controller.sv -----
`timescale 1ns / 1ps
// Move-and-turn PID controller, one input word per control tick.
// in_ch carries the tick: fresh odometry, obstacle distance and a movement
// command, each with its own valid flag. out_ch carries one word of linear and
// angular speed for each tick that drives a move; ticks with no move active
// give no word. cfg_ch writes the gains and tolerances by register index and
// is always ready; write it only while the block is idle.
// An input word is taken only when the controller is idle. A tick with no move
// active returns to idle straight from the check. A tick that drives a move
// reaches the output register after checking, squaring and loading, a square
// root that resolves two radicand bits per cycle, and two passes, distance
// then heading, through the one shared gain multiplier.
// With a ready receiver a new word is taken only once the last one is through.
// The result waits in the output register, so the next word is taken while a
// stalled receiver still holds the last one; a second result then waits in the
// controller until the register frees.
// Reset clears the control state, held inputs, sums and flags and restores the default gains and tolerances.
module move_turn_pid_controller (
	input logic     clk,
	input logic     arst_n,
	mtp_in_if.sink  in_ch,
	mtp_out_if.source out_ch,
	mtp_cfg_if.sink cfg_ch
);

	mtp_pkg::cmd_t    cmd;
	mtp_pkg::status_t status;

	assign cfg_ch.ready = 1'b1;

	mtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mtp_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_valid         (cfg_ch.valid),
		.cfg_index         (cfg_ch.index),
		.cfg_data          (cfg_ch.data),
		.odom_valid        (in_ch.odom_valid),
		.pos_x             (in_ch.pos_x),
		.pos_y             (in_ch.pos_y),
		.yaw               (in_ch.yaw),
		.obstacle_valid    (in_ch.obstacle_valid),
		.obstacle_distance (in_ch.obstacle_distance),
		.cmd_valid         (in_ch.cmd_valid),
		.cmd_translation   (in_ch.cmd_translation),
		.cmd_rotation      (in_ch.cmd_rotation),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.linear_speed      (out_ch.linear_speed),
		.angular_speed     (out_ch.angular_speed)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

	localparam longint PI_A = 12868;
	localparam longint TWO_PI_A = 2 * PI_A;
	localparam longint TERM_LIM = 64'sd1 <<< 54;
	localparam longint RAW_LIM = 64'sd1 <<< 40;
	localparam int WATCHDOG = 20000;

	typedef struct {
		bit odom_v; int px; int py; int yw;
		bit obs_v; int obs;
		bit cmd_v; int ctr; int crot;
		bit has_exp; int e_lin; int e_ang;
	} tick_t;

	typedef struct { int lin; int ang; } speed_t;

	logic clk = 0;
	logic arst_n = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	mtp_in_if in_ch();
	mtp_out_if out_ch();
	mtp_cfg_if cfg_ch();

	move_turn_pid_controller DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// Predictor state.
	longint kp, ki, kd, safety, dtol, atol;
	longint hx, hy, hyaw, hobs, sx, sy, dtarget, htarget;
	bit odom_ok, obs_ok, pending, moving, turning;
	longint dsum, dlast, tsum, tlast;

	speed_t speeds_due[$];
	int fails = 0;
	int n_items = 0, n_words = 0, n_moves = 0;
	int idle_pct = 0, stall_pct = 0;
	bit hold_off = 0;
	int quiet = 0;

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint sat_sum(longint s, longint e);
		longint hi = (64'sd1 <<< (mtp_pkg::SUM_WIDTH - 1)) - 1;
		longint t = s + e;
		if (t > hi) return hi;
		if (t < -hi - 1) return -hi - 1;
		return t;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint gain_mul(longint g, longint v);
		longint unsigned m, p;
		if (g == 0) return 0;
		m = absv(v);
		if (m > (64'd1 << 62) / g) return v < 0 ? -TERM_LIM : TERM_LIM;
		p = m * g;
		if (v < 0) return -longint'((p + 255) >> 8);
		return longint'(p >> 8);
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void reset_model();
		kp = 128; ki = 0; kd = 0; safety = 32768; dtol = 6554; atol = 819;
		hx = 0; hy = 0; hyaw = 0; hobs = 0; sx = 0; sy = 0; dtarget = 0; htarget = 0;
		odom_ok = 0; obs_ok = 0; pending = 0; moving = 0; turning = 0;
		dsum = 0; dlast = 0; tsum = 0; tlast = 0;
	endfunction

	function automatic void model_cfg(logic [mtp_pkg::CFG_IDX_W-1:0] idx, longint v);
		case (idx)
			mtp_pkg::REG_GAIN_P: kp = v & 16'hFFFF;
			mtp_pkg::REG_GAIN_I: ki = v & 16'hFFFF;
			mtp_pkg::REG_GAIN_D: kd = v & 16'hFFFF;
			mtp_pkg::REG_SAFETY: safety = v & 32'h7FFFFFFF;
			mtp_pkg::REG_DIST_TOL: dtol = v & 32'h7FFFFFFF;
			mtp_pkg::REG_ANGLE_TOL: atol = v & 14'h3FFF;
			default: ;
		endcase
	endfunction

	// Returns 1 when the tick yields a speed word.
	function automatic bit control_tick(tick_t t, output speed_t sp);
		longint lin = 0, ang = 0, err, d, raw;
		longint unsigned mx, my, a, s;
		longint travel;
		bit blocked;
		sp.lin = 0; sp.ang = 0;
		if (t.odom_v) begin
			hx = t.px; hy = t.py; hyaw = t.yw; odom_ok = 1;
		end
		if (t.obs_v) begin
			hobs = t.obs; obs_ok = 1;
		end
		if (t.cmd_v) begin
			dtarget = t.ctr; htarget = t.crot; pending = 1;
		end
		if (pending && odom_ok && obs_ok) begin
			pending = 0; sx = hx; sy = hy; moving = 1; turning = 1;
			htarget += hyaw;
			tlast = htarget;
			if (htarget > PI_A) htarget -= TWO_PI_A;
			if (htarget < -PI_A) htarget += TWO_PI_A;
			n_moves++;
		end
		if (!(odom_ok && moving && obs_ok)) return 0;
		mx = absv(sx - hx); my = absv(sy - hy);
		a = mx * mx; s = a + my * my;
		travel = (s < a) ? 64'sd4294967295 : longint'(root64(s));
		err = dtarget - travel;
		if (absv(err) > hobs) err = hobs;
		blocked = absv(hobs) < safety;
		moving = (absv(err) > dtol) && !blocked;
		if (moving) begin
			d = err - dlast;
			dsum = sat_sum(dsum, err);
			lin = clip32(gain_mul(kp, err) + gain_mul(ki, dsum) + gain_mul(kd, d));
			dlast = err;
		end else begin
			obs_ok = 0;
		end
		if (turning) begin
			err = htarget - hyaw;
			if (err > PI_A) err -= TWO_PI_A;
			else if (err < -PI_A) err += TWO_PI_A;
			turning = absv(err) > atol;
			if (turning) begin
				d = err - tlast;
				tsum = sat_sum(tsum, err);
				raw = gain_mul(kp, err) + gain_mul(ki, tsum) + gain_mul(kd, d);
				if (raw > RAW_LIM) raw = RAW_LIM;
				if (raw < -RAW_LIM) raw = -RAW_LIM;
				ang = clip32(raw * (64'sd1 <<< (mtp_pkg::POS_FRAC_BITS
					- mtp_pkg::ANGLE_FRAC_BITS)));
				tlast = err;
			end
		end
		if (ang > 0) sp.ang = int'(ang);
		else sp.lin = int'(lin);
		return 1;
	endfunction

	// Receiver side with random stalls and optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		speed_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_words++;
			if (speeds_due.size() == 0) begin
				$error("speed word with none expected");
				fails++;
			end else begin
				e = speeds_due.pop_front();
				if (out_ch.linear_speed !== e.lin) begin
					$error("linear_speed expected %0d actual %0d", e.lin, out_ch.linear_speed);
					fails++;
				end
				if (out_ch.angular_speed !== e.ang) begin
					$error("angular_speed expected %0d actual %0d", e.ang, out_ch.angular_speed);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Valid stays high between back-to-back words; it drops only for idling and in drain.
	task automatic send_tick(tick_t t);
		speed_t sp;
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.odom_valid <= t.odom_v;
		in_ch.pos_x <= t.px; in_ch.pos_y <= t.py; in_ch.yaw <= 15'(t.yw);
		in_ch.obstacle_valid <= t.obs_v;
		in_ch.obstacle_distance <= t.obs;
		in_ch.cmd_valid <= t.cmd_v;
		in_ch.cmd_translation <= t.ctr; in_ch.cmd_rotation <= 15'(t.crot);
		do @(posedge clk); while (!in_ch.ready);
		n_items++;
		if (control_tick(t, sp)) begin
			if (t.has_exp && (sp.lin != t.e_lin || sp.ang != t.e_ang)) begin
				$error("table row disagrees: lin %0d/%0d ang %0d/%0d",
					t.e_lin, sp.lin, t.e_ang, sp.ang);
				fails++;
			end
			speeds_due.push_back(sp);
		end else if (t.has_exp) begin
			$error("table row expected a word, none predicted");
			fails++;
		end
	endtask

	task automatic drain();
		int spin = 0;
		in_ch.valid <= 0;
		while (speeds_due.size() != 0 && spin < 200000) begin
			@(posedge clk);
			spin++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [mtp_pkg::CFG_IDX_W-1:0] idx, longint v);
		cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= 32'(v);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		@(posedge clk);
		model_cfg(idx, v);
	endtask

	function automatic int rand_angle();
		return int'($urandom_range(2 * PI_A)) - int'(PI_A);
	endfunction

	function automatic int rand_word();
		return int'($urandom);
	endfunction

	function automatic tick_t blank();
		tick_t t;
		t = '{default: 0};
		return t;
	endfunction

	// A move: a first tick with odometry, obstacle and a command, then odometry steps.
	task automatic random_move();
		tick_t t;
		int x = rand_word() >>> $urandom_range(31, 10);
		int y = rand_word() >>> $urandom_range(31, 10);
		int steps = $urandom_range(12, 2);
		t = blank();
		t.odom_v = 1; t.px = x; t.py = y; t.yw = rand_angle();
		t.obs_v = 1; t.obs = $urandom_range(8, 0) == 0 ? rand_word() : $urandom_range(2000000);
		t.cmd_v = 1; t.ctr = rand_word() >>> $urandom_range(31, 12); t.crot = rand_angle();
		send_tick(t);
		for (int i = 0; i < steps; i++) begin
			t = blank();
			t.odom_v = $urandom_range(9) != 0;
			x += int'($urandom_range(40000)) - 20000;
			y += int'($urandom_range(40000)) - 20000;
			t.px = x; t.py = y; t.yw = rand_angle();
			t.obs_v = $urandom_range(3) == 0; t.obs = $urandom_range(3000000);
			t.cmd_v = $urandom_range(15) == 0; t.ctr = rand_word() >>> 12;
			t.crot = rand_angle();
			send_tick(t);
		end
	endtask

	task automatic random_noise();
		tick_t t;
		t = blank();
		t.odom_v = $urandom_range(1); t.px = rand_word(); t.py = rand_word();
		t.yw = rand_angle();
		t.obs_v = $urandom_range(1); t.obs = rand_word();
		t.cmd_v = $urandom_range(1); t.ctr = rand_word(); t.crot = rand_angle();
		send_tick(t);
	endtask

	task automatic random_cfg(bit extreme);
		if (extreme) begin
			write_reg(mtp_pkg::REG_GAIN_P, $urandom_range(1) ? 16'hFFFF : 0);
			write_reg(mtp_pkg::REG_GAIN_I, $urandom_range(1) ? 16'hFFFF : 0);
			write_reg(mtp_pkg::REG_GAIN_D, $urandom_range(1) ? 16'hFFFF : 0);
			write_reg(mtp_pkg::REG_SAFETY, $urandom_range(1) ? 32'h7FFFFFFF : 0);
			write_reg(mtp_pkg::REG_DIST_TOL, $urandom_range(1) ? 32'h7FFFFFFF : 0);
			write_reg(mtp_pkg::REG_ANGLE_TOL, $urandom_range(1) ? 12868 : 0);
		end else begin
			write_reg(mtp_pkg::REG_GAIN_P, $urandom_range(65535));
			write_reg(mtp_pkg::REG_GAIN_I, $urandom_range(1023));
			write_reg(mtp_pkg::REG_GAIN_D, $urandom_range(4095));
			write_reg(mtp_pkg::REG_SAFETY, $urandom_range(65536));
			write_reg(mtp_pkg::REG_DIST_TOL, $urandom_range(20000));
			write_reg(mtp_pkg::REG_ANGLE_TOL, $urandom_range(2000));
		end
	endtask

	initial begin
		tick_t rows[$];
		tick_t t;
		in_ch.valid = 0; in_ch.odom_valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0;
		in_ch.yaw = 0; in_ch.obstacle_valid = 0; in_ch.obstacle_distance = 0;
		in_ch.cmd_valid = 0; in_ch.cmd_translation = 0; in_ch.cmd_rotation = 0;
		cfg_ch.valid = 0; cfg_ch.index = mtp_pkg::REG_GAIN_P; cfg_ch.data = 0;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table: no data yet, a command alone, blocked moves, extremes.
		t = blank(); rows.push_back(t);
		t = blank(); t.cmd_v = 1; t.ctr = 65536; rows.push_back(t);
		t = blank(); t.odom_v = 1; rows.push_back(t);
		// Obstacle at zero is below safety: word of zeros, move ends.
		t = blank(); t.obs_v = 1; t.has_exp = 1; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.obs_v = 1; t.obs = 32'sh40000000;
		t.cmd_v = 1; t.ctr = 655360; t.crot = 12868; t.yw = 12868; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.px = 32'sh7FFFFFFF; t.py = 32'sh80000000;
		t.yw = -12868; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.px = 32'sh80000000; t.py = 32'sh7FFFFFFF;
		t.yw = 14'sh1FFF; rows.push_back(t);
		t = blank(); t.obs_v = 1; t.obs = 32'sh80000000; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.obs_v = 1; t.obs = 32'sh7FFFFFFF; t.cmd_v = 1;
		t.ctr = 32'sh80000000; t.crot = -12868; t.yw = -12868; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.px = 100; t.py = -100; t.yw = 0; rows.push_back(t);
		t = blank(); t.cmd_v = 1; t.ctr = 32'sh7FFFFFFF; t.crot = 0;
		t.obs_v = 1; t.obs = 32'sh7FFFFFFF; rows.push_back(t);
		t = blank(); t.cmd_v = 1; t.ctr = 1000; rows.push_back(t);
		t = blank(); t.odom_v = 1; t.obs_v = 1; t.obs = -5; t.cmd_v = 1;
		t.ctr = 65536; rows.push_back(t);
		foreach (rows[i]) send_tick(rows[i]);
		drain();

		write_reg(mtp_pkg::REG_GAIN_P, 16'hFFFF); write_reg(mtp_pkg::REG_GAIN_I, 16'hFFFF);
		write_reg(mtp_pkg::REG_GAIN_D, 16'hFFFF); write_reg(mtp_pkg::REG_SAFETY, 0);
		write_reg(mtp_pkg::REG_DIST_TOL, 0); write_reg(mtp_pkg::REG_ANGLE_TOL, 0);
		for (int i = 0; i < 6; i++) random_move();
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 66; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 66; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			random_cfg(ph == 4 || ph == 7);
			if (ph == 2) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
					for (int i = 0; i < 3; i++) random_move();
				join
			end
			while (n_items < 125 * (ph + 1)) begin
				if ($urandom_range(4) == 0) random_noise();
				else random_move();
			end
			drain();
		end

		$display("tb: %0d ticks sent, %0d speed words checked, %0d moves started",
			n_items, n_words, n_moves);
		$display("tb: covered gain and tolerance extremes, stalls, idles and hold-off");
		if (fails == 0 && speeds_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
